FILE: rtl/core/quad_diode_beam_position_assert.svh
// assertion macros for the quad diode beam position block
`ifndef QUAD_DIODE_BEAM_POSITION_ASSERT_SVH
`define QUAD_DIODE_BEAM_POSITION_ASSERT_SVH

// same-cycle implication
`define QDBP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define QDBP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/qdbp_pkg.sv
// shared types and constants of the beam position block
package qdbp_pkg;

    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 34;
    localparam int GAIN_W   = 24;
    localparam int PROD_W   = 58;
    localparam int QUO_W    = 33;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam int LANES    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GEOMETRY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_I  = 4'd3;

    localparam logic GEOM_SLIT     = 1'b0;
    localparam logic GEOM_QUADRANT = 1'b1;

    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 24'sd65536;
    localparam logic signed [SUM_W-1:0] NOSIG_LIMIT = 34'sd655;
    localparam logic signed [SUM_W-1:0] NOSIG_DIV   = 34'sd6553600;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 32'sh80000000;

    typedef struct packed {
        logic                     geometry;
        logic signed [GAIN_W-1:0] scale_x;
        logic signed [GAIN_W-1:0] scale_y;
        logic signed [GAIN_W-1:0] scale_i;
    } qdbp_cfg_t;

    typedef struct packed {
        logic signed [PROD_W-1:0]   num_x;
        logic signed [PROD_W-1:0]   num_y;
        logic signed [SUM_W-1:0]    div_x;
        logic signed [SUM_W-1:0]    div_y;
        logic signed [SAMPLE_W-1:0] intensity;
        logic                       last;
    } qdbp_div_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x_position;
        logic signed [SAMPLE_W-1:0] y_position;
        logic signed [SAMPLE_W-1:0] intensity;
        logic                       last;
    } qdbp_result_t;

    typedef struct packed {
        logic [SUM_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
        logic [SUM_W-1:0] den;
        logic             neg;
        logic             ovf;
    } qdbp_lane_t;

endpackage

FILE: rtl/core/qdbp_if.sv
// stream and configuration channel interfaces
interface qdbp_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [qdbp_pkg::SAMPLE_W-1:0] sample_a;
    logic signed [qdbp_pkg::SAMPLE_W-1:0] sample_b;
    logic signed [qdbp_pkg::SAMPLE_W-1:0] sample_c;
    logic signed [qdbp_pkg::SAMPLE_W-1:0] sample_d;
    logic                              last_sample;
    modport source (output valid, sample_a, sample_b, sample_c, sample_d, last_sample,
                    input ready);
    modport sink (input valid, sample_a, sample_b, sample_c, sample_d, last_sample,
                  output ready);
endinterface

interface qdbp_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [qdbp_pkg::SAMPLE_W-1:0] x_position;
    logic signed [qdbp_pkg::SAMPLE_W-1:0] y_position;
    logic signed [qdbp_pkg::SAMPLE_W-1:0] intensity;
    logic                              last_result;
    modport source (output valid, x_position, y_position, intensity, last_result,
                    input ready);
    modport sink (input valid, x_position, y_position, intensity, last_result,
                  output ready);
endinterface

interface qdbp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [qdbp_pkg::CFG_IDX_W-1:0]      index;
    logic [qdbp_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/qdbp_front.sv
// sums, gain products, divisor guard and intensity scaling
module qdbp_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  qdbp_pkg::qdbp_cfg_t            cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [31:0]             sample_a,
    input  logic signed [31:0]             sample_b,
    input  logic signed [31:0]             sample_c,
    input  logic signed [31:0]             sample_d,
    input  logic                           last_sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output qdbp_pkg::qdbp_div_in_t         out_data
);
    import qdbp_pkg::*;
    `include "quad_diode_beam_position_assert.svh"

    localparam int NSTG = 3;

    logic [NSTG-1:0] v_reg, v_next, en;

    // stage 1
    logic signed [SUM_W-1:0] nx1_reg, dx1_reg, ny1_reg, dy1_reg, sum1_reg;
    logic signed [SUM_W-1:0] nx1_next, dx1_next, ny1_next, dy1_next, sum1_next;
    logic last1_reg;
    // stage 2
    logic signed [PROD_W-1:0] px2_reg, py2_reg, pi2_reg, px2_next, py2_next, pi2_next;
    logic signed [SUM_W-1:0] dx2_reg, dy2_reg, dx2_next, dy2_next;
    logic last2_reg;
    // stage 3
    qdbp_div_in_t o3_reg, o3_next;

    logic signed [SUM_W-1:0] ea, eb, ec, ed;
    logic signed [PROD_W-1:0] pi_rnd;
    logic signed [PROD_W-17:0] pi_sh;

    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int i = 1; i < NSTG; i++)
        begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NSTG-1];
    assign out_data  = o3_reg;

    always_comb
    begin
        ea = SUM_W'(sample_a);
        eb = SUM_W'(sample_b);
        ec = SUM_W'(sample_c);
        ed = SUM_W'(sample_d);
        sum1_next = ea + eb + ec + ed;
        if (cfg.geometry == GEOM_SLIT)
        begin
            nx1_next = ea - ec;
            dx1_next = ea + ec;
            ny1_next = ed - eb;
            dy1_next = ed + eb;
        end
        else
        begin
            nx1_next = (ea + ed) - (eb + ec);
            dx1_next = sum1_next;
            ny1_next = (ea + eb) - (ec + ed);
            dy1_next = sum1_next;
        end
    end

    always_comb
    begin
        px2_next = nx1_reg * cfg.scale_x;
        py2_next = ny1_reg * cfg.scale_y;
        pi2_next = sum1_reg * cfg.scale_i;
        dx2_next = (dx1_reg >= -NOSIG_LIMIT && dx1_reg <= NOSIG_LIMIT) ? NOSIG_DIV : dx1_reg;
        dy2_next = (dy1_reg >= -NOSIG_LIMIT && dy1_reg <= NOSIG_LIMIT) ? NOSIG_DIV : dy1_reg;
    end

    // intensity: truncate toward zero by 2^16, then clamp
    always_comb
    begin
        pi_rnd = pi2_reg + (pi2_reg[PROD_W-1] ? 58'sd65535 : 58'sd0);
        pi_sh  = pi_rnd[PROD_W-1:16];
        o3_next.num_x = px2_reg;
        o3_next.num_y = py2_reg;
        o3_next.div_x = dx2_reg;
        o3_next.div_y = dy2_reg;
        o3_next.last  = last2_reg;
        if (pi_sh > 42'(SAT_MAX))
        begin
            o3_next.intensity = SAT_MAX;
        end
        else if (pi_sh < 42'(SAT_MIN))
        begin
            o3_next.intensity = SAT_MIN;
        end
        else
        begin
            o3_next.intensity = pi_sh[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            nx1_reg <= nx1_next;
            dx1_reg <= dx1_next;
            ny1_reg <= ny1_next;
            dy1_reg <= dy1_next;
            sum1_reg <= sum1_next;
            last1_reg <= last_sample;
        end
        if (en[1])
        begin
            px2_reg <= px2_next;
            py2_reg <= py2_next;
            pi2_reg <= pi2_next;
            dx2_reg <= dx2_next;
            dy2_reg <= dy2_next;
            last2_reg <= last1_reg;
        end
        if (en[2])
        begin
            o3_reg <= o3_next;
        end
    end

    `QDBP_ASSERT_IMP(a_div_guarded, v_reg[1],
        (dx2_reg > NOSIG_LIMIT || dx2_reg < -NOSIG_LIMIT) &&
        (dy2_reg > NOSIG_LIMIT || dy2_reg < -NOSIG_LIMIT))

endmodule

FILE: rtl/core/qdbp_div.sh.sv
// restoring divider pipeline, one quotient bit per stage, two lanes
module qdbp_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  qdbp_pkg::qdbp_div_in_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output qdbp_pkg::qdbp_result_t out_data
);
    import qdbp_pkg::*;
    `include "quad_diode_beam_position_assert.svh"

    // entry stage, QUO_W step stages, final stage
    localparam int NSTG = QUO_W + 2;

    logic [NSTG-1:0] v_reg, v_next, en;

    qdbp_lane_t lane_reg   [QUO_W+1][LANES];
    qdbp_lane_t entry_next [LANES];
    qdbp_lane_t lane_next  [QUO_W][LANES];
    logic signed [SAMPLE_W-1:0] inten_reg [QUO_W+1];
    logic last_reg [QUO_W+1];
    qdbp_result_t res_reg, res_next;

    logic signed [PROD_W-1:0] num_in [LANES];
    logic signed [SUM_W-1:0]  den_in [LANES];
    logic [PROD_W-1:0] mag_n [LANES];
    logic [SUM_W-1:0]  mag_d [LANES];
    logic [SUM_W:0]    trial [QUO_W][LANES];
    logic signed [SAMPLE_W-1:0] lane_res [LANES];

    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int i = 1; i < NSTG; i++)
        begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NSTG-1];
    assign out_data  = res_reg;

    // entry: magnitudes, sign and overflow precheck
    always_comb
    begin
        num_in[0] = in_data.num_x;
        num_in[1] = in_data.num_y;
        den_in[0] = in_data.div_x;
        den_in[1] = in_data.div_y;
        for (int l = 0; l < LANES; l++)
        begin
            mag_n[l] = num_in[l][PROD_W-1] ? PROD_W'(-num_in[l]) : PROD_W'(num_in[l]);
            mag_d[l] = den_in[l][SUM_W-1] ? SUM_W'(-den_in[l]) : SUM_W'(den_in[l]);
            entry_next[l].rem = SUM_W'(mag_n[l][PROD_W-1:QUO_W]);
            entry_next[l].low = mag_n[l][QUO_W-1:0];
            entry_next[l].quo = '0;
            entry_next[l].den = mag_d[l];
            entry_next[l].neg = num_in[l][PROD_W-1] ^ den_in[l][SUM_W-1];
            entry_next[l].ovf = SUM_W'(mag_n[l][PROD_W-1:QUO_W]) >= mag_d[l];
        end
    end

    // one quotient bit per stage
    always_comb
    begin
        for (int k = 0; k < QUO_W; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial[k][l] = {lane_reg[k][l].rem, lane_reg[k][l].low[QUO_W-1]};
                lane_next[k][l] = lane_reg[k][l];
                lane_next[k][l].low = {lane_reg[k][l].low[QUO_W-2:0], 1'b0};
                if (trial[k][l] >= {1'b0, lane_reg[k][l].den})
                begin
                    lane_next[k][l].rem = SUM_W'(trial[k][l] - {1'b0, lane_reg[k][l].den});
                    lane_next[k][l].quo = {lane_reg[k][l].quo[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    lane_next[k][l].rem = trial[k][l][SUM_W-1:0];
                    lane_next[k][l].quo = {lane_reg[k][l].quo[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // sign and clamp
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (lane_reg[QUO_W][l].ovf ||
                (!lane_reg[QUO_W][l].neg && lane_reg[QUO_W][l].quo > 33'h07fffffff) ||
                (lane_reg[QUO_W][l].neg && lane_reg[QUO_W][l].quo > 33'h080000000))
            begin
                lane_res[l] = lane_reg[QUO_W][l].neg ? SAT_MIN : SAT_MAX;
            end
            else if (lane_reg[QUO_W][l].neg)
            begin
                lane_res[l] = SAMPLE_W'(-lane_reg[QUO_W][l].quo);
            end
            else
            begin
                lane_res[l] = lane_reg[QUO_W][l].quo[SAMPLE_W-1:0];
            end
        end
        res_next.x_position = lane_res[0];
        res_next.y_position = lane_res[1];
        res_next.intensity  = inten_reg[QUO_W];
        res_next.last       = last_reg[QUO_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lane_reg[0] <= entry_next;
            inten_reg[0] <= in_data.intensity;
            last_reg[0] <= in_data.last;
        end
        for (int k = 1; k <= QUO_W; k++)
        begin
            if (en[k])
            begin
                lane_reg[k] <= lane_next[k-1];
                inten_reg[k] <= inten_reg[k-1];
                last_reg[k] <= last_reg[k-1];
            end
        end
        if (en[NSTG-1])
        begin
            res_reg <= res_next;
        end
    end

    `QDBP_ASSERT_IMP(a_rem_below_den, v_reg[0] && !lane_reg[0][0].ovf,
        lane_reg[0][0].rem < lane_reg[0][0].den)
    `QDBP_ASSERT_IMP(a_mid_rem_below_den, v_reg[QUO_W] && !lane_reg[QUO_W][1].ovf,
        lane_reg[QUO_W][1].rem < lane_reg[QUO_W][1].den)

endmodule

FILE: rtl/core/quad_diode_beam_position.sv
// top level of the quad diode beam position block
// 38 register stages: 3 front, 35 divider
// throughput: one item per cycle without backpressure, set by the one-bit-per-stage restoring divider
// pipeline; backpressure stalls only the stages holding items, bubbles close up
// reset: asynchronous active low, clears all stage valid bits and loads
// geometry slit and all gains 1.0
module quad_diode_beam_position (
    input  logic clk,
    input  logic rst_n,
    qdbp_cfg_if.sink   cfg,
    qdbp_in_if.sink    in_chan,
    qdbp_out_if.source out_chan
);
    import qdbp_pkg::*;
    `include "quad_diode_beam_position_assert.svh"

    qdbp_cfg_t cfg_reg;

    // front to divider handoff
    logic         mid_valid;
    logic         mid_ready;
    qdbp_div_in_t mid_data;
    qdbp_result_t res;

    // register writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.geometry <= GEOM_SLIT;
            cfg_reg.scale_x  <= GAIN_ONE;
            cfg_reg.scale_y  <= GAIN_ONE;
            cfg_reg.scale_i  <= GAIN_ONE;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_GEOMETRY: cfg_reg.geometry <= cfg.data[0];
                REG_SCALE_X:  cfg_reg.scale_x  <= cfg.data;
                REG_SCALE_Y:  cfg_reg.scale_y  <= cfg.data;
                REG_SCALE_I:  cfg_reg.scale_i  <= cfg.data;
                default:      ; // unknown index is ignored
            endcase
        end
    end

    // sums, differences, gain products and intensity
    qdbp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_chan.valid),
        .in_ready    (in_chan.ready),
        .sample_a    (in_chan.sample_a),
        .sample_b    (in_chan.sample_b),
        .sample_c    (in_chan.sample_c),
        .sample_d    (in_chan.sample_d),
        .last_sample (in_chan.last_sample),
        .out_valid   (mid_valid),
        .out_ready   (mid_ready),
        .out_data    (mid_data)
    );

    // x and y division lanes in lockstep
    qdbp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_data   (mid_data),
        .out_valid (out_chan.valid),
        .out_ready (out_chan.ready),
        .out_data  (res)
    );

    assign out_chan.x_position  = res.x_position;
    assign out_chan.y_position  = res.y_position;
    assign out_chan.intensity   = res.intensity;
    assign out_chan.last_result = res.last;

    // input stalls only when the whole chain is full and the output is held
    `QDBP_ASSERT_IMP(a_stall_cause, !in_chan.ready, out_chan.valid && !out_chan.ready)

endmodule

FILE: tb/qdbp_tb_if.sv
// shared testbench constants
package qdbp_tb_pkg;
    localparam int BEAM_WATCHDOG = 20000;
endpackage

FILE: tb/tb.sv
// self-checking testbench of the quad diode beam position block
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qdbp_pkg::*;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    qdbp_cfg_if cfg_ch();
    qdbp_in_if in_ch();
    qdbp_out_if out_ch();

    quad_diode_beam_position DUT (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_ch), .in_chan(in_ch), .out_chan(out_ch)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    typedef struct {
        logic signed [31:0] a, b, c, d;
        logic               last;
        logic               known;   // expected result typed into the row
        qdbp_result_t       res;
    } beam_row_t;

    // shadow copy of the block registers
    logic              geom;
    logic signed [23:0] gain_x, gain_y, gain_i;

    qdbp_result_t pending_results[$];
    int  errors = 0;
    int  idle_cycles = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_receiver = 0;
    bit  hold_go = 0;

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint scaled_ratio(longint num, longint gain, longint dv);
        longint q;
        if (dv >= -655 && dv <= 655) dv = 6553600;
        q = (num * gain) / dv;
        return q;
    endfunction

    // expected position and intensity for one diode sample
    function automatic qdbp_result_t beam_predict(beam_row_t r);
        qdbp_result_t o;
        longint a, b, c, d, s;
        a = r.a; b = r.b; c = r.c; d = r.d;
        s = a + b + c + d;
        if (geom == GEOM_SLIT)
        begin
            o.x_position = clip32(scaled_ratio(a - c, gain_x, a + c));
            o.y_position = clip32(scaled_ratio(d - b, gain_y, d + b));
        end
        else
        begin
            o.x_position = clip32(scaled_ratio((a + d) - (b + c), gain_x, s));
            o.y_position = clip32(scaled_ratio((a + b) - (c + d), gain_y, s));
        end
        o.intensity = clip32((s * longint'(gain_i)) / 65536);
        o.last = r.last;
        return o;
    endfunction

    // write one register, idle block only
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        case (idx)
            REG_GEOMETRY: geom   = val[0];
            REG_SCALE_X:  gain_x = val;
            REG_SCALE_Y:  gain_y = val;
            REG_SCALE_I:  gain_i = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // wait until every result has come, then let the pipeline drain
    task automatic drain_block();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // offer one item; valid stays high across back-to-back items
    task automatic send_sample(beam_row_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid       <= 1'b1;
        in_ch.sample_a    <= r.a;
        in_ch.sample_b    <= r.b;
        in_ch.sample_c    <= r.c;
        in_ch.sample_d    <= r.d;
        in_ch.last_sample <= r.last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        pending_results.push_back(r.known ? r.res : beam_predict(r));
    endtask

    task automatic end_burst();
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_sample();
        case ($urandom_range(5))
            0: return 32'sh7fffffff - $urandom_range(3);
            1: return 32'sh80000000 + $urandom_range(3);
            2: return $signed($urandom_range(1400)) - 700;   // near the no-signal band
            3: return $signed($urandom_range(2000000)) - 1000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic beam_row_t random_row();
        beam_row_t r;
        r.a = pick_sample(); r.b = pick_sample();
        r.c = pick_sample(); r.d = pick_sample();
        r.last = 1'($urandom_range(1));
        r.known = 0;
        return r;
    endfunction

    // directed rows: extremes, no-signal divisors, saturation
    beam_row_t directed[$];
    task automatic fill_directed();
        beam_row_t r;
        r.known = 0;
        // all zero after reset: divisor replaced, everything zero
        r = '{0, 0, 0, 0, 1'b0, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 1'b0}};
        directed.push_back(r);
        // one unit on A with gain one: x = 1.0, intensity = 1.0
        r = '{32'sd65536, 0, 0, 0, 1'b1, 1'b1, '{32'sd65536, 32'sd0, 32'sd65536, 1'b1}};
        directed.push_back(r);
        // slit divisor exactly on the no-signal edges
        r = '{32'sd655, 0, 0, 0, 1'b0, 1'b0, '{0, 0, 0, 0}}; directed.push_back(r);
        r = '{32'sd656, 0, 0, 0, 1'b0, 1'b0, '{0, 0, 0, 0}}; directed.push_back(r);
        r = '{-32'sd655, 0, 0, 32'sd656, 1'b1, 1'b0, '{0, 0, 0, 0}}; directed.push_back(r);
        r = '{-32'sd656, 32'sd1, 0, -32'sd655, 1'b0, 1'b0, '{0, 0, 0, 0}};
        directed.push_back(r);
        // extremes: the all-equal rows saturate the intensity
        r = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1, 1'b0,
              '{0, 0, 0, 0}};
        directed.push_back(r);
        r = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, 1'b0,
              '{0, 0, 0, 0}};
        directed.push_back(r);
        r = '{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1'b1, 1'b0,
              '{0, 0, 0, 0}};
        directed.push_back(r);
        r = '{32'sh7fffffff, 32'sd1, 32'sh80000000, 32'sd0, 1'b0, 1'b0, '{0, 0, 0, 0}};
        directed.push_back(r);
        r = '{32'sd700, -32'sd700, 32'sd1, 32'sh7fffffff, 1'b1, 1'b0, '{0, 0, 0, 0}};
        directed.push_back(r);
    endtask

    // result checker
    always @(posedge clk)
    begin
        qdbp_result_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result x=%0d y=%0d i=%0d", $time,
                         out_ch.x_position, out_ch.y_position, out_ch.intensity);
            end
            else
            begin
                e = pending_results.pop_front();
                if (out_ch.x_position !== e.x_position)
                begin
                    errors++;
                    $display("%0t: x_position expected %0d actual %0d", $time,
                             e.x_position, out_ch.x_position);
                end
                if (out_ch.y_position !== e.y_position)
                begin
                    errors++;
                    $display("%0t: y_position expected %0d actual %0d", $time,
                             e.y_position, out_ch.y_position);
                end
                if (out_ch.intensity !== e.intensity)
                begin
                    errors++;
                    $display("%0t: intensity expected %0d actual %0d", $time,
                             e.intensity, out_ch.intensity);
                end
                if (out_ch.last_result !== e.last)
                begin
                    errors++;
                    $display("%0t: last_result expected %0b actual %0b", $time,
                             e.last, out_ch.last_result);
                end
            end
        end
    end

    // receiver ready, random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_receiver)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || hold_receiver || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > qdbp_tb_pkg::BEAM_WATCHDOG)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // long receiver hold-off counted in its own process
    initial
    begin
        wait (hold_go === 1'b1);
        hold_receiver = 1;
        repeat (200) @(posedge clk);
        hold_receiver = 0;
    end

    initial
    begin
        beam_row_t r;
        cfg_ch.valid = 0; cfg_ch.index = '0; cfg_ch.data = '0;
        in_ch.valid = 0; in_ch.sample_a = 0; in_ch.sample_b = 0;
        in_ch.sample_c = 0; in_ch.sample_d = 0; in_ch.last_sample = 0;
        out_ch.ready = 0;
        geom = GEOM_SLIT; gain_x = GAIN_ONE; gain_y = GAIN_ONE; gain_i = GAIN_ONE;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table at reset settings, then again in quadrant geometry
        fill_directed();
        send_idle_pct = 18; recv_idle_pct = 60;
        foreach (directed[k]) send_sample(directed[k]);
        end_burst();
        drain_block();
        write_reg(REG_GEOMETRY, 24'(GEOM_QUADRANT));
        write_reg(REG_UNUSED, 24'hffffff);   // unknown index is ignored
        foreach (directed[k])
        begin
            r = directed[k];
            r.known = 0;
            send_sample(r);
        end
        end_burst();
        drain_block();

        // random phases, each with its own register setting
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 18; recv_idle_pct = 60; end
                2: begin send_idle_pct = 60; recv_idle_pct = 18; end
                4: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                default: ;
            endcase
            write_reg(REG_GEOMETRY, 24'(ph[0]));
            case (ph)
                1: begin write_reg(REG_SCALE_X, 24'h7fffff); write_reg(REG_SCALE_Y, 24'h800000);
                         write_reg(REG_SCALE_I, 24'h7fffff); end
                3: begin write_reg(REG_SCALE_X, 24'h800000); write_reg(REG_SCALE_Y, 24'h7fffff);
                         write_reg(REG_SCALE_I, 24'h800000); end
                5: begin write_reg(REG_SCALE_X, 24'h000000); write_reg(REG_SCALE_Y, 24'h000001);
                         write_reg(REG_SCALE_I, 24'hffffff); end
                default: begin write_reg(REG_SCALE_X, 24'($urandom));
                               write_reg(REG_SCALE_Y, 24'($urandom));
                               write_reg(REG_SCALE_I, 24'($urandom)); end
            endcase
            // receiver holds off while the sender keeps offering, block fills up
            if (ph == 4) hold_go = 1;
            repeat (85) send_sample(random_row());
            end_burst();
            // sender pauses until every result is back
            drain_block();
        end
        drain_block();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/qdbp_pkg.sv
rtl/core/qdbp_if.sv
rtl/core/qdbp_front.sv
rtl/core/qdbp_div.sh.sv
rtl/core/quad_diode_beam_position.sv
tb/qdbp_tb_if.sv
tb/tb.sv
